[hdl/cpu_bus_decoder_with_bank_mapper_assert.svh]
// ----------------------------------------------------------------------------
// CPU bus decoder assertion macros
// Short forms for the clocked, reset-qualified checks used in the RTL.
// ----------------------------------------------------------------------------
`ifndef CPU_BUS_DECODER_WITH_BANK_MAPPER_ASSERT_SVH
`define CPU_BUS_DECODER_WITH_BANK_MAPPER_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define CBD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cbd: same-cycle check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define CBD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cbd: next-cycle check failed");

`endif

[hdl/cbd_pkg.sv]
// ----------------------------------------------------------------------------
// CPU bus decoder package
// Beat types, region codes, address limits and system register indexes.
// ----------------------------------------------------------------------------
package cbd_pkg;

  // Region reported with every access.
  typedef enum logic [2:0] {
    REGION_RAM      = 3'd0,
    REGION_PROGRAM  = 3'd1,
    REGION_VIDEO    = 3'd2,
    REGION_SYSREG   = 3'd3,
    REGION_UNMAPPED = 3'd4
  } region_e;

  // Input beat: one CPU bus access.
  typedef struct packed {
    logic        command;
    logic [15:0] cpu_address;
    logic [7:0]  write_data;
  } req_t;

  // Output beat: the decoded access.
  typedef struct packed {
    logic [2:0]  target_region;
    logic [24:0] physical_address;
    logic [7:0]  read_data;
  } rsp_t;

  // System register write, as seen by the bank mapper.
  typedef struct packed {
    logic       en;
    logic [7:0] idx;
    logic [7:0] data;
  } reg_wr_t;

  // Access command codes.
  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  // Address map limits.
  localparam logic [15:0] RAM_END     = 16'h1FFF;
  localparam logic [15:0] VIDEO_END   = 16'h20FF;
  localparam logic [15:0] SYSREG_END  = 16'h21FF;
  localparam logic [15:0] PROG_BASE   = 16'h4000;

  // Fixed bank values for the last windows.
  localparam logic [7:0] BANK_FIXED_FE = 8'hFE;
  localparam logic [7:0] BANK_FIXED_FF = 8'hFF;

  // System register indexes used by the bank mapper.
  localparam logic [7:0] REG_BANK1_R3  = 8'h00;
  localparam logic [7:0] REG_COMR      = 8'h05;
  localparam logic [7:0] REG_BANK0_R0  = 8'h07;
  localparam logic [7:0] REG_BANK0_R1  = 8'h08;
  localparam logic [7:0] REG_BANK0_R2  = 8'h09;
  localparam logic [7:0] REG_BANK0_R3  = 8'h0A;
  localparam logic [7:0] REG_BANK0_SEL = 8'h0B;
  localparam logic [7:0] REG_BANK1_R2  = 8'h0C;
  localparam logic [7:0] REG_BANK1_R0  = 8'h10;
  localparam logic [7:0] REG_BANK1_R1  = 8'h11;
  localparam logic [7:0] REG_BANK0_R4  = 8'h12;
  localparam logic [7:0] REG_BANK0_R5  = 8'h13;
  localparam logic [7:0] REG_BANK1_R45 = 8'h18;
  localparam logic [7:0] REG_EXT       = 8'h1C;

  // Upper six bits shared by the swapped alias registers 0x10 to 0x13.
  localparam logic [5:0] ALIAS_GROUP = 6'h04;

  // Window codes from address bits 15..13.
  localparam logic [2:0] WIN_2 = 3'd2;
  localparam logic [2:0] WIN_3 = 3'd3;
  localparam logic [2:0] WIN_4 = 3'd4;
  localparam logic [2:0] WIN_5 = 3'd5;
  localparam logic [2:0] WIN_6 = 3'd6;

  // Mask of the bank bits taken from the window register; the rest come
  // from bank register 0x0A. Select seven takes all bits from the window.
  function automatic logic [7:0] bank_mask(input logic [2:0] sel);
    logic [7:0] mask;
    unique case (sel)
      3'd0:    mask = 8'h3F;
      3'd1:    mask = 8'h1F;
      3'd2:    mask = 8'h0F;
      3'd3:    mask = 8'h07;
      3'd4:    mask = 8'h03;
      3'd5:    mask = 8'h01;
      3'd6:    mask = 8'h00;
      default: mask = 8'hFF;
    endcase
    return mask;
  endfunction

endpackage

[hdl/cbd_ram.sv]
// ----------------------------------------------------------------------------
// Generic synchronous RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module cbd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                       rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write and registered read; read data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/cbd_bank_mapper.sv]
// ----------------------------------------------------------------------------
// Program bank mapper
// Keeps copies of the bank control registers and forms the 25-bit physical
// address for program space accesses.
// ----------------------------------------------------------------------------
module cbd_bank_mapper (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cbd_pkg::reg_wr_t reg_wr_i,
  input  logic [15:0]      cpu_address_i,
  output logic [24:0]      physical_address_o
);

  // Copies of the bank registers, only the bits that the mapping uses.
  logic       comr6_q,  comr6_d;
  logic       pq2en_q,  pq2en_d;
  logic [2:0] sel_q,    sel_d;
  logic       ext5_q,   ext5_d;
  logic [7:0] b0r0_q,   b0r0_d;
  logic [7:0] b0r1_q,   b0r1_d;
  logic [7:0] b0r2_q,   b0r2_d;
  logic [7:0] b0r3_q,   b0r3_d;
  logic [7:0] b0r4_q,   b0r4_d;
  logic [7:0] b0r5_q,   b0r5_d;
  logic [3:0] b1r0_q,   b1r0_d;
  logic [3:0] b1r1_q,   b1r1_d;
  logic [3:0] b1r2_q,   b1r2_d;
  logic [3:0] b1r3_q,   b1r3_d;
  logic [7:0] b1r45_q,  b1r45_d;

  logic [2:0] win;
  logic [2:0] eff;
  logic [7:0] tp;
  logic [3:0] hi;
  logic [7:0] mask;
  logic [7:0] mid;

  // Register copies follow system register writes to their index.
  always_comb begin
    comr6_d = comr6_q;
    pq2en_d = pq2en_q;
    sel_d   = sel_q;
    ext5_d  = ext5_q;
    b0r0_d  = b0r0_q;
    b0r1_d  = b0r1_q;
    b0r2_d  = b0r2_q;
    b0r3_d  = b0r3_q;
    b0r4_d  = b0r4_q;
    b0r5_d  = b0r5_q;
    b1r0_d  = b1r0_q;
    b1r1_d  = b1r1_q;
    b1r2_d  = b1r2_q;
    b1r3_d  = b1r3_q;
    b1r45_d = b1r45_q;
    if (reg_wr_i.en) begin
      unique case (reg_wr_i.idx)
        cbd_pkg::REG_BANK1_R3:  b1r3_d  = reg_wr_i.data[3:0];
        cbd_pkg::REG_COMR:      comr6_d = reg_wr_i.data[6];
        cbd_pkg::REG_BANK0_R0:  b0r0_d  = reg_wr_i.data;
        cbd_pkg::REG_BANK0_R1:  b0r1_d  = reg_wr_i.data;
        cbd_pkg::REG_BANK0_R2:  b0r2_d  = reg_wr_i.data;
        cbd_pkg::REG_BANK0_R3:  b0r3_d  = reg_wr_i.data;
        cbd_pkg::REG_BANK0_SEL: begin
          pq2en_d = reg_wr_i.data[6];
          sel_d   = reg_wr_i.data[2:0];
        end
        cbd_pkg::REG_BANK1_R2:  b1r2_d  = reg_wr_i.data[3:0];
        cbd_pkg::REG_BANK1_R0:  b1r0_d  = reg_wr_i.data[3:0];
        cbd_pkg::REG_BANK1_R1:  b1r1_d  = reg_wr_i.data[3:0];
        cbd_pkg::REG_BANK0_R4:  b0r4_d  = reg_wr_i.data;
        cbd_pkg::REG_BANK0_R5:  b0r5_d  = reg_wr_i.data;
        cbd_pkg::REG_BANK1_R45: b1r45_d = reg_wr_i.data;
        cbd_pkg::REG_EXT:       ext5_d  = reg_wr_i.data[5];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      comr6_q <= 1'b0;
      pq2en_q <= 1'b0;
      sel_q   <= '0;
      ext5_q  <= 1'b0;
      b0r0_q  <= '0;
      b0r1_q  <= '0;
      b0r2_q  <= '0;
      b0r3_q  <= '0;
      b0r4_q  <= '0;
      b0r5_q  <= '0;
      b1r0_q  <= '0;
      b1r1_q  <= '0;
      b1r2_q  <= '0;
      b1r3_q  <= '0;
      b1r45_q <= '0;
    end else begin
      comr6_q <= comr6_d;
      pq2en_q <= pq2en_d;
      sel_q   <= sel_d;
      ext5_q  <= ext5_d;
      b0r0_q  <= b0r0_d;
      b0r1_q  <= b0r1_d;
      b0r2_q  <= b0r2_d;
      b0r3_q  <= b0r3_d;
      b0r4_q  <= b0r4_d;
      b0r5_q  <= b0r5_d;
      b1r0_q  <= b1r0_d;
      b1r1_q  <= b1r1_d;
      b1r2_q  <= b1r2_d;
      b1r3_q  <= b1r3_d;
      b1r45_q <= b1r45_d;
    end
  end

  // Window selection; windows four and six swap when COMR bit 6 is set.
  assign win = cpu_address_i[15:13];
  assign eff = (comr6_q && (win == cbd_pkg::WIN_4 || win == cbd_pkg::WIN_6)) ?
               (win ^ 3'b010) : win;

  // Bank value and extension nibble for the window.
  always_comb begin
    unique case (eff)
      cbd_pkg::WIN_2: begin
        tp = b0r4_q;
        hi = b1r45_q[3:0];
      end
      cbd_pkg::WIN_3: begin
        tp = b0r5_q;
        hi = b1r45_q[7:4];
      end
      cbd_pkg::WIN_4: begin
        tp = b0r0_q;
        hi = b1r0_q;
      end
      cbd_pkg::WIN_5: begin
        tp = b0r1_q;
        hi = b1r1_q;
      end
      cbd_pkg::WIN_6: begin
        tp = pq2en_q ? b0r2_q : cbd_pkg::BANK_FIXED_FE;
        hi = pq2en_q ? b1r2_q : b1r3_q;
      end
      default: begin
        tp = cbd_pkg::BANK_FIXED_FF;
        hi = b1r3_q;
      end
    endcase
    // The extension override applies to the upper half of the address space.
    if (ext5_q && cpu_address_i[15]) begin
      hi = b1r3_q;
    end
  end

  // Merge the window bank with register 0x0A under the selected mask.
  assign mask = cbd_pkg::bank_mask(sel_q);
  assign mid  = (b0r3_q & ~mask) | (tp & mask);

  assign physical_address_o = {hi, mid, cpu_address_i[12:0]};

endmodule

[hdl/cpu_bus_decoder_with_bank_mapper.sv]
// Latency: a result beat is valid in the cycle after its access beat is taken.
// Throughput: one access per cycle unless a held result beat stalls the input;
// the register file RAM has one read and one write port and is read in the
// accept cycle, so back-to-back accesses to the same register need no stall.
// Reset: valid bits and bank register copies clear at once, so every system
// register reads zero right after reset; there is no clearing pass.
// ----------------------------------------------------------------------------
// CPU bus decoder with bank mapper
// Classifies each CPU access, translates program space addresses and keeps
// the 256-byte system register file.
// ----------------------------------------------------------------------------
`include "cpu_bus_decoder_with_bank_mapper_assert.svh"

module cpu_bus_decoder_with_bank_mapper (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  cbd_pkg::req_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output cbd_pkg::rsp_t out_data_o
);

  localparam int unsigned RegDepth = 256;

  logic             accept;
  logic [15:0]      addr;
  logic [7:0]       idx;
  logic [7:0]       rd_idx;
  cbd_pkg::region_e region;
  logic [24:0]      pa;
  logic [24:0]      prog_pa;
  logic             sys_wr;
  logic             sys_rd;
  cbd_pkg::reg_wr_t reg_wr;
  logic [7:0]       ram_rdata;

  logic [RegDepth-1:0] valid_q, valid_d;
  logic                out_valid_q, out_valid_d;
  logic [2:0]          region_q;
  logic [24:0]         pa_q;
  logic                rd_hit_q;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign addr       = in_data_i.cpu_address;
  assign idx        = addr[7:0];

  // Region decode and physical address; program addresses come from the bank mapper.
  always_comb begin
    pa = '0;
    priority if (addr <= cbd_pkg::RAM_END) begin
      region = cbd_pkg::REGION_RAM;
      pa     = {9'd0, addr};
    end else if (addr >= cbd_pkg::PROG_BASE) begin
      region = cbd_pkg::REGION_PROGRAM;
      pa     = prog_pa;
    end else if (addr <= cbd_pkg::VIDEO_END) begin
      region = cbd_pkg::REGION_VIDEO;
      pa     = {17'd0, idx};
    end else if (addr <= cbd_pkg::SYSREG_END) begin
      region = cbd_pkg::REGION_SYSREG;
      pa     = {17'd0, idx};
    end else begin
      region = cbd_pkg::REGION_UNMAPPED;
    end
  end

  // Register file access strobes; reads of 0x10 to 0x13 use swapped aliases.
  assign sys_wr = accept && (region == cbd_pkg::REGION_SYSREG) &&
                  (in_data_i.command == cbd_pkg::CMD_WRITE);
  assign sys_rd = accept && (region == cbd_pkg::REGION_SYSREG) &&
                  (in_data_i.command == cbd_pkg::CMD_READ);
  assign rd_idx = (idx[7:2] == cbd_pkg::ALIAS_GROUP) ? (idx ^ 8'h02) : idx;

  assign reg_wr.en   = sys_wr;
  assign reg_wr.idx  = idx;
  assign reg_wr.data = in_data_i.write_data;

  cbd_ram #(
    .Width (8),
    .Depth (RegDepth)
  ) u_reg_ram (
    .clk_i   (clk_i),
    .we_i    (sys_wr),
    .waddr_i (idx),
    .wdata_i (in_data_i.write_data),
    .re_i    (sys_rd),
    .raddr_i (rd_idx),
    .rdata_o (ram_rdata)
  );

  cbd_bank_mapper u_bank_mapper (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .reg_wr_i           (reg_wr),
    .cpu_address_i      (addr),
    .physical_address_o (prog_pa)
  );

  // Written-entry tracking: an entry never written reads as zero.
  always_comb begin
    valid_d = valid_q;
    if (sys_wr) begin
      valid_d[idx] = 1'b1;
    end
  end

  // Output handshake state.
  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      valid_q     <= valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output payload register; the RAM registers its read data at the same edge.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      region_q <= region;
      pa_q     <= pa;
      rd_hit_q <= sys_rd && valid_q[rd_idx];
    end
  end

  assign out_valid_o                 = out_valid_q;
  assign out_data_o.target_region    = region_q;
  assign out_data_o.physical_address = pa_q;
  assign out_data_o.read_data        = rd_hit_q ? ram_rdata : 8'd0;

  // A result beat outside the system register region carries zero read data.
  `CBD_ASSERT_SAME(a_rdata_zero, clk_i, rst_ni,
    out_valid_q && (region_q != cbd_pkg::REGION_SYSREG), out_data_o.read_data == 8'd0)

  // Unmapped accesses report a zero physical address.
  `CBD_ASSERT_SAME(a_unmapped_pa, clk_i, rst_ni,
    out_valid_q && (region_q == cbd_pkg::REGION_UNMAPPED), pa_q == 25'd0)

  // A register write marks its entry as written.
  `CBD_ASSERT_NEXT(a_wr_marks_valid, clk_i, rst_ni,
    sys_wr, valid_q[$past(idx)])

  // A stalled result beat stays in place.
  `CBD_ASSERT_NEXT(a_stall_holds, clk_i, rst_ni,
    out_valid_q && !out_ready_i, out_valid_q && $stable(pa_q) && $stable(region_q))

endmodule
